// ----- rtl/dpc_pkg.sv -----
package dpc_pkg;

   localparam int MAX_POINTS = 512;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int LABEL_W    = IDX_W + 1;
   localparam int COORD_W    = 10;
   localparam int RD_IDX_W   = 9;
   localparam int LBLOUT_W   = 9;
   localparam int TOTAL_W    = 10;
   localparam int MINPTS_W   = 10;
   localparam int EPS_W      = 11;
   localparam int DIST_W     = 2 * EPS_W;
   localparam int CSR_IDX_W  = 1;

   localparam logic [MINPTS_W-1:0] MINPTS_RESET = MINPTS_W'(1);
   localparam int                  EPS_RESET    = 95;

   localparam logic [LABEL_W-1:0] LBL_UNSEEN = '1;
   localparam logic [LABEL_W-1:0] LBL_NOISE  = LBL_UNSEEN - LABEL_W'(1);

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_READ  = 1'b1;
   localparam logic KIND_DONE  = 1'b0;
   localparam logic KIND_LABEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = CSR_IDX_W'(1);

   typedef struct packed {
      logic                mode;
      logic [COORD_W-1:0]  point_x;
      logic [COORD_W-1:0]  point_y;
      logic                last_point;
      logic [RD_IDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [LBLOUT_W-1:0] cluster_label;
      logic                is_noise;
      logic [TOTAL_W-1:0]  cluster_total;
      logic                overflow_flag;
      logic                index_invalid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_OUTER,
      ST_OUTCHK,
      ST_CORE,
      ST_COUNT,
      ST_DECIDE,
      ST_MARK,
      ST_QCHK,
      ST_QSEED,
      ST_QCORE,
      ST_EXPAND,
      ST_DONE,
      ST_READ
   } state_type;

endpackage

// ----- rtl/dpc_ram.sv -----
module dpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dpc_near.sv -----
module dpc_near (
   input  logic [dpc_pkg::COORD_W-1:0] ax,
   input  logic [dpc_pkg::COORD_W-1:0] ay,
   input  logic [dpc_pkg::COORD_W-1:0] bx,
   input  logic [dpc_pkg::COORD_W-1:0] by,
   input  logic [dpc_pkg::DIST_W-1:0]  eps_sq,
   output logic                        near
);
   import dpc_pkg::*;

   logic [COORD_W-1:0]   dx;
   logic [COORD_W-1:0]   dy;
   logic [2*COORD_W-1:0] dx_sq;
   logic [2*COORD_W-1:0] dy_sq;
   logic [2*COORD_W:0]   dist_sq;

   always_comb begin
      dx      = (ax > bx) ? (ax - bx) : (bx - ax);
      dy      = (ay > by) ? (ay - by) : (by - ay);
      dx_sq   = dx * dx;
      dy_sq   = dy * dy;
      dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
      near    = DIST_W'(dist_sq) <= eps_sq;
   end

endmodule

// ----- rtl/dbscan_point_clustering.sv -----
// A load word without last_point is taken in idle and leaves the block idle. A label read
// is answered from ST_READ, which waits for a free response slot; no new word is taken until then.
// A load with last_point runs label init over the loaded points, then one neighbour
// scan per counted point and per expanded core, each through the single read port
// of the point memory.
// Synchronous reset clears control state and configuration; the point, label and
// seed memories are not cleared and hold nothing valid until written.
module dbscan_point_clustering (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dpc_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dpc_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpc_pkg::EPS_W-1:0]     csr_data
);
   import dpc_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    loaded_ff, loaded_in;
   logic [CNT_W-1:0]    counter_ff, counter_in;
   logic                overflow_ff, overflow_in;
   logic                closed_ff, closed_in;
   logic [MINPTS_W-1:0] min_pts_ff;
   logic [DIST_W-1:0]   eps_sq_ff;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    core_ff, core_in;
   logic [COORD_W-1:0]  cx_ff, cx_in;
   logic [COORD_W-1:0]  cy_ff, cy_in;
   logic                seed_ph_ff, seed_ph_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                pv_ff, pv_in;
   logic [IDX_W-1:0]    pj_ff, pj_in;
   logic [CNT_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    tail_ff, tail_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_inv_ff, rd_inv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                   xy_we;
   logic [IDX_W-1:0]       xy_waddr;
   logic [2*COORD_W-1:0]   xy_wdata;
   logic [IDX_W-1:0]       xy_raddr;
   logic [2*COORD_W-1:0]   xy_rdata;
   logic                   lb_we;
   logic [IDX_W-1:0]       lb_waddr;
   logic [LABEL_W-1:0]     lb_wdata;
   logic [IDX_W-1:0]       lb_raddr;
   logic [LABEL_W-1:0]     lb_rdata;
   logic                   sq_we;
   logic [IDX_W-1:0]       sq_waddr;
   logic [IDX_W-1:0]       sq_wdata;
   logic [IDX_W-1:0]       sq_raddr;
   logic [IDX_W-1:0]       sq_rdata;

   logic                req_fire;
   logic                rsp_free;
   logic                scan_state;
   logic                issue;
   logic                scan_end;
   logic                near;
   logic                low_count;
   logic [CNT_W-1:0]    base;
   logic [LABEL_W-1:0]  cur_id;

   dpc_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_xy_ram (
      .clock   (clock),
      .wr_en   (xy_we),
      .wr_addr (xy_waddr),
      .wr_data (xy_wdata),
      .rd_addr (xy_raddr),
      .rd_data (xy_rdata)
   );

   dpc_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_POINTS)) u_label_ram (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (lb_waddr),
      .wr_data (lb_wdata),
      .rd_addr (lb_raddr),
      .rd_data (lb_rdata)
   );

   dpc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_seed_ram (
      .clock   (clock),
      .wr_en   (sq_we),
      .wr_addr (sq_waddr),
      .wr_data (sq_wdata),
      .rd_addr (sq_raddr),
      .rd_data (sq_rdata)
   );

   dpc_near u_near (
      .ax     (cx_ff),
      .ay     (cy_ff),
      .bx     (xy_rdata[2*COORD_W-1:COORD_W]),
      .by     (xy_rdata[COORD_W-1:0]),
      .eps_sq (eps_sq_ff),
      .near   (near)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   assign scan_state = (state_ff == ST_COUNT) || (state_ff == ST_MARK) ||
                       (state_ff == ST_EXPAND);
   assign issue      = scan_state && (scan_ff < loaded_ff);
   assign scan_end   = scan_state && (scan_ff == loaded_ff) && !pv_ff;
   assign low_count  = int'(count_ff) < int'(min_pts_ff);
   assign cur_id     = LABEL_W'(counter_ff);
   assign base       = closed_ff ? '0 : loaded_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.mode == MODE_READ) begin
                  state_in = ST_READ;
               end else if (req_payload.last_point) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            if (i_ff == loaded_ff) begin
               state_in = ST_OUTER;
            end
         end
         ST_OUTER:  state_in = (i_ff < loaded_ff) ? ST_OUTCHK : ST_DONE;
         ST_OUTCHK: state_in = (lb_rdata == LBL_UNSEEN) ? ST_CORE : ST_OUTER;
         ST_CORE:   state_in = ST_COUNT;
         ST_COUNT: begin
            if (scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (low_count) begin
               state_in = seed_ph_ff ? ST_QCHK : ST_OUTER;
            end else begin
               state_in = seed_ph_ff ? ST_EXPAND : ST_MARK;
            end
         end
         ST_MARK: begin
            if (scan_end) begin
               state_in = ST_QCHK;
            end
         end
         ST_EXPAND: begin
            if (scan_end) begin
               state_in = ST_QCHK;
            end
         end
         ST_QCHK:  state_in = (head_ff < tail_ff) ? ST_QSEED : ST_OUTER;
         ST_QSEED: state_in = ST_QCORE;
         ST_QCORE: state_in = ST_COUNT;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      loaded_in    = loaded_ff;
      counter_in   = counter_ff;
      overflow_in  = overflow_ff;
      closed_in    = closed_ff;
      i_in         = i_ff;
      core_in      = core_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      seed_ph_in   = seed_ph_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pv_in        = issue;
      pj_in        = scan_ff[IDX_W-1:0];
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_idx_in    = rd_idx_ff;
      rd_inv_in    = rd_inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      xy_we        = 1'b0;
      xy_waddr     = base[IDX_W-1:0];
      xy_wdata     = {req_payload.point_x, req_payload.point_y};
      xy_raddr     = scan_ff[IDX_W-1:0];
      lb_we        = 1'b0;
      lb_waddr     = pj_ff;
      lb_wdata     = cur_id;
      lb_raddr     = scan_ff[IDX_W-1:0];
      sq_we        = 1'b0;
      sq_waddr     = tail_ff[IDX_W-1:0];
      sq_wdata     = pj_ff;
      sq_raddr     = head_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            lb_raddr = IDX_W'(req_payload.read_index);
            if (req_fire) begin
               if (req_payload.mode == MODE_LOAD) begin
                  closed_in = 1'b0;
                  if (closed_ff) begin
                     counter_in  = '0;
                     overflow_in = 1'b0;
                  end
                  if (int'(base) < MAX_POINTS) begin
                     xy_we     = 1'b1;
                     loaded_in = base + CNT_W'(1);
                  end else begin
                     loaded_in   = base;
                     overflow_in = 1'b1;
                  end
                  if (req_payload.last_point) begin
                     i_in       = '0;
                     counter_in = '0;
                  end
               end else begin
                  rd_idx_in = IDX_W'(req_payload.read_index);
                  rd_inv_in = !closed_ff ||
                              (int'(req_payload.read_index) >= int'(loaded_ff));
               end
            end
         end
         ST_INIT: begin
            if (i_ff < loaded_ff) begin
               lb_we    = 1'b1;
               lb_waddr = i_ff[IDX_W-1:0];
               lb_wdata = LBL_UNSEEN;
               i_in     = i_ff + CNT_W'(1);
            end else begin
               i_in = '0;
            end
         end
         ST_OUTER: begin
            lb_raddr = i_ff[IDX_W-1:0];
         end
         ST_OUTCHK: begin
            if (lb_rdata == LBL_UNSEEN) begin
               xy_raddr = i_ff[IDX_W-1:0];
               core_in  = i_ff[IDX_W-1:0];
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ST_CORE, ST_QCORE: begin
            cx_in      = xy_rdata[2*COORD_W-1:COORD_W];
            cy_in      = xy_rdata[COORD_W-1:0];
            seed_ph_in = (state_ff == ST_QCORE);
            scan_in    = '0;
            count_in   = '0;
         end
         ST_COUNT: begin
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pv_ff && near) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            if (low_count) begin
               if (!seed_ph_ff) begin
                  lb_we    = 1'b1;
                  lb_waddr = core_ff;
                  lb_wdata = LBL_NOISE;
                  i_in     = i_ff + CNT_W'(1);
               end
            end else begin
               scan_in = '0;
               if (!seed_ph_ff) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
         ST_MARK: begin
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pv_ff && near) begin
               lb_we = 1'b1;
               if ((pj_ff != core_ff) && (int'(tail_ff) < MAX_POINTS)) begin
                  sq_we   = 1'b1;
                  tail_in = tail_ff + CNT_W'(1);
               end
            end
         end
         ST_EXPAND: begin
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pv_ff && near) begin
               if (lb_rdata == LBL_UNSEEN) begin
                  lb_we = 1'b1;
                  if (int'(tail_ff) < MAX_POINTS) begin
                     sq_we   = 1'b1;
                     tail_in = tail_ff + CNT_W'(1);
                  end
               end else if (lb_rdata == LBL_NOISE) begin
                  lb_we = 1'b1;
               end
            end
         end
         ST_QCHK: begin
            if (head_ff < tail_ff) begin
               head_in = head_ff + CNT_W'(1);
            end else begin
               counter_in = counter_ff + CNT_W'(1);
               i_in       = i_ff + CNT_W'(1);
            end
         end
         ST_QSEED: begin
            xy_raddr = sq_rdata;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_kind   = KIND_DONE;
               rsp_in.cluster_label = '0;
               rsp_in.is_noise      = 1'b0;
               rsp_in.cluster_total = TOTAL_W'(counter_ff);
               rsp_in.overflow_flag = overflow_ff;
               rsp_in.index_invalid = 1'b0;
               closed_in            = 1'b1;
            end
         end
         ST_READ: begin
            lb_raddr = rd_idx_ff;
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_kind   = KIND_LABEL;
               rsp_in.cluster_total = TOTAL_W'(counter_ff);
               rsp_in.overflow_flag = overflow_ff;
               rsp_in.index_invalid = rd_inv_ff;
               if (rd_inv_ff) begin
                  rsp_in.cluster_label = '0;
                  rsp_in.is_noise      = 1'b0;
               end else if ((lb_rdata == LBL_UNSEEN) || (lb_rdata == LBL_NOISE)) begin
                  rsp_in.cluster_label = '0;
                  rsp_in.is_noise      = 1'b1;
               end else begin
                  rsp_in.cluster_label = LBLOUT_W'(lb_rdata);
                  rsp_in.is_noise      = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         counter_ff   <= '0;
         overflow_ff  <= 1'b0;
         closed_ff    <= 1'b0;
         min_pts_ff   <= MINPTS_RESET;
         eps_sq_ff    <= DIST_W'(EPS_RESET * EPS_RESET);
         i_ff         <= '0;
         scan_ff      <= '0;
         pv_ff        <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         seed_ph_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         counter_ff   <= counter_in;
         overflow_ff  <= overflow_in;
         closed_ff    <= closed_in;
         i_ff         <= i_in;
         scan_ff      <= scan_in;
         pv_ff        <= pv_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         seed_ph_ff   <= seed_ph_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_POINTS) begin
               min_pts_ff <= MINPTS_W'(csr_data);
            end else if (csr_index == CSR_EPSILON) begin
               eps_sq_ff <= DIST_W'(csr_data) * DIST_W'(csr_data);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      core_ff   <= core_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      count_ff  <= count_in;
      pj_ff     <= pj_in;
      rd_idx_ff <= rd_idx_in;
      rd_inv_ff <= rd_inv_in;
      rsp_ff    <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=>
         (rsp_valid_ff && rsp_ff.result_kind == KIND_DONE && closed_ff))
      else $error("done report not issued");

   assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("seed queue head passed tail");

   assert property (@(posedge clock) disable iff (reset)
      int'(tail_ff) <= MAX_POINTS)
      else $error("seed queue overrun");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.mode == MODE_READ) |=>
         (state_ff == ST_READ && rd_inv_ff == !$past(closed_ff) ||
          state_ff == ST_READ && $past(closed_ff)))
      else $error("label read not started");

endmodule

// ----- tb/dbscan_point_clustering_tb.sv -----
module dbscan_point_clustering_tb;
   import dpc_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_POINTS;
   logic [EPS_W-1:0]     csr_data = '0;

   // Shadow of the block: point set, labels and configuration.
   int             pt_x [MAX_POINTS];
   int             pt_y [MAX_POINTS];
   logic [LABEL_W-1:0] pt_label [MAX_POINTS];
   int             grow_queue [MAX_POINTS];
   int             n_loaded = 0;
   int             n_clusters = 0;
   bit             dropped_seen = 0;
   bit             set_done = 0;
   int             cfg_min_pts = 1;
   int             cfg_eps = 95;

   rsp_type        pending_rsps [$];
   int             errors = 0;
   int             words_sent = 0;
   int             idle_phase = 0;
   bit             hold_req = 0;
   int             hold_left = 0;

   dbscan_point_clustering DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 6_000_000);
      $display("FAILURE");
      $finish;
   end

   function automatic int sender_gap_pct();
      return (idle_phase == 1) ? 46 : (idle_phase == 3) ? 8 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_phase == 2) ? 46 : (idle_phase == 3) ? 8 : 0;
   endfunction

   function automatic bit is_near(int a, int b);
      int dx;
      int dy;
      dx = pt_x[a] - pt_x[b];
      dy = pt_y[a] - pt_y[b];
      return dx * dx + dy * dy <= cfg_eps * cfg_eps;
   endfunction

   function automatic int count_near(int c);
      int n;
      n = 0;
      for (int j = 0; j < n_loaded; j++) if (is_near(c, j)) n++;
      return n;
   endfunction

   function automatic bit grow_cluster(int core, int id);
      int head;
      int tail;
      int s;
      head = 0;
      tail = 0;
      if (count_near(core) < cfg_min_pts) begin
         pt_label[core] = LBL_NOISE;
         return 0;
      end
      // The first neighbourhood is taken over even from earlier clusters.
      for (int j = 0; j < n_loaded; j++) begin
         if (is_near(core, j)) begin
            pt_label[j] = LABEL_W'(id);
            if (j != core && tail < MAX_POINTS) grow_queue[tail++] = j;
         end
      end
      while (head < tail) begin
         s = grow_queue[head++];
         if (count_near(s) >= cfg_min_pts) begin
            for (int j = 0; j < n_loaded; j++) begin
               if (is_near(s, j)) begin
                  if (pt_label[j] == LBL_UNSEEN) begin
                     if (tail < MAX_POINTS) grow_queue[tail++] = j;
                     pt_label[j] = LABEL_W'(id);
                  end else if (pt_label[j] == LBL_NOISE) begin
                     pt_label[j] = LABEL_W'(id);
                  end
               end
            end
         end
      end
      return 1;
   endfunction

   function automatic void cluster_points();
      n_clusters = 0;
      for (int i = 0; i < n_loaded; i++) pt_label[i] = LBL_UNSEEN;
      for (int i = 0; i < n_loaded; i++)
         if (pt_label[i] == LBL_UNSEEN && grow_cluster(i, n_clusters)) n_clusters++;
   endfunction

   function automatic void predict_word(req_type w);
      rsp_type r;
      int idx;
      r = '0;
      if (w.mode == MODE_LOAD) begin
         if (set_done) begin
            n_loaded = 0;
            n_clusters = 0;
            dropped_seen = 0;
            set_done = 0;
         end
         if (n_loaded < MAX_POINTS) begin
            pt_x[n_loaded] = w.point_x;
            pt_y[n_loaded] = w.point_y;
            n_loaded++;
         end else begin
            dropped_seen = 1;
         end
         if (w.last_point) begin
            cluster_points();
            set_done = 1;
            r.result_kind = KIND_DONE;
            r.cluster_total = TOTAL_W'(n_clusters);
            r.overflow_flag = dropped_seen;
            pending_rsps = {pending_rsps, r};
         end
      end else begin
         idx = w.read_index;
         r.result_kind = KIND_LABEL;
         r.cluster_total = TOTAL_W'(n_clusters);
         r.overflow_flag = dropped_seen;
         if (!set_done || idx >= n_loaded) begin
            r.index_invalid = 1'b1;
         end else if (pt_label[idx] == LBL_UNSEEN || pt_label[idx] == LBL_NOISE) begin
            r.is_noise = 1'b1;
         end else begin
            r.cluster_label = LBLOUT_W'(pt_label[idx]);
         end
         pending_rsps = {pending_rsps, r};
      end
   endfunction

   // Leaves valid high on return so that back-to-back words need no gap.
   task automatic send_word(req_type w);
      if ($urandom_range(99) < sender_gap_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_gap_pct()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(w);
      words_sent++;
   endtask

   task automatic load_point(int x, int y, bit last);
      req_type w;
      w = '0;
      w.mode = MODE_LOAD;
      w.point_x = COORD_W'(x);
      w.point_y = COORD_W'(y);
      w.last_point = last;
      w.read_index = RD_IDX_W'($urandom);
      send_word(w);
   endtask

   task automatic read_label(int idx, bit last);
      req_type w;
      w = '0;
      w.mode = MODE_READ;
      w.read_index = RD_IDX_W'(idx);
      w.last_point = last;
      w.point_x = COORD_W'($urandom_range(800));
      w.point_y = COORD_W'($urandom_range(800));
      send_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= EPS_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MIN_POINTS) cfg_min_pts = value & 10'h3FF;
      else cfg_eps = value & 11'h7FF;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_set(int n, bit with_noise);
      int cx;
      int cy;
      for (int i = 0; i < n; i++) begin
         if (i % 5 == 0) begin
            cx = $urandom_range(800);
            cy = $urandom_range(800);
         end
         if ($urandom_range(3) == 0)
            load_point($urandom_range(800), $urandom_range(800), i == n - 1);
         else
            load_point((cx + $urandom_range(60)) % 801, (cy + $urandom_range(60)) % 801,
                       i == n - 1);
         if (with_noise && $urandom_range(9) == 0) read_label($urandom_range(511), 1'b0);
      end
   endtask

   task automatic read_set(int k, int n);
      for (int i = 0; i < k; i++) begin
         if ($urandom_range(7) == 0) read_label($urandom_range(511), $urandom_range(1));
         else read_label($urandom_range(n), $urandom_range(1));
      end
   endtask

   task automatic test_directed();
      idle_phase = 0;
      read_label(0, 1'b0);
      load_point(0, 0, 1'b0);
      load_point(800, 800, 1'b0);
      load_point(800, 0, 1'b0);
      load_point(0, 800, 1'b0);
      load_point(1, 1, 1'b0);
      load_point(512, 512, 1'b1);
      for (int i = 0; i < 7; i++) read_label(i, i == 3);
      read_label(511, 1'b0);
      drain();
      write_reg(CSR_MIN_POINTS, 0);
      write_reg(CSR_EPSILON, 1132);
      load_point(0, 0, 1'b0);
      load_point(800, 800, 1'b1);
      read_label(0, 1'b0);
      read_label(1, 1'b0);
      drain();
      write_reg(CSR_MIN_POINTS, 512);
      write_reg(CSR_EPSILON, 0);
      load_point(5, 5, 1'b0);
      load_point(5, 5, 1'b1);
      read_label(1, 1'b0);
      drain();
   endtask

   task automatic test_overflow();
      write_reg(CSR_MIN_POINTS, 1);
      write_reg(CSR_EPSILON, 0);
      idle_phase = 0;
      for (int i = 0; i <= MAX_POINTS; i++)
         load_point($urandom_range(800), $urandom_range(800), i == MAX_POINTS);
      read_label(0, 1'b0);
      read_label(511, 1'b0);
      read_set(10, 511);
      drain();
   endtask

   task automatic test_pressure();
      idle_phase = 0;
      write_reg(CSR_MIN_POINTS, 2);
      write_reg(CSR_EPSILON, 95);
      load_set(12, 1'b0);
      hold_req = 1;
      read_set(60, 14);
      drain();
   endtask

   task automatic test_random();
      int n;
      int eps_pick [8];
      eps_pick = '{0, 1, 10, 40, 95, 200, 600, 1132};
      while (words_sent < 1170) begin
         if ($urandom_range(5) == 0) begin
            drain();
            write_reg(CSR_MIN_POINTS, ($urandom_range(9) == 0) ? $urandom_range(512)
                                                                 : $urandom_range(1, 6));
            write_reg(CSR_EPSILON, ($urandom_range(3) == 0) ? $urandom_range(1132)
                                                             : eps_pick[$urandom_range(7)]);
         end
         idle_phase = $urandom_range(3);
         n = ($urandom_range(19) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 20);
         load_set(n, $urandom_range(4) == 0);
         read_set($urandom_range(2, 12), n + 2);
      end
      drain();
   endtask

   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 400;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, rsp_payload);
            errors++;
         end else begin
            want = pending_rsps.pop_front();
            check_field("result_kind", want.result_kind, rsp_payload.result_kind);
            check_field("cluster_label", want.cluster_label, rsp_payload.cluster_label);
            check_field("is_noise", want.is_noise, rsp_payload.is_noise);
            check_field("cluster_total", want.cluster_total, rsp_payload.cluster_total);
            check_field("overflow_flag", want.overflow_flag, rsp_payload.overflow_flag);
            check_field("index_invalid", want.index_invalid, rsp_payload.index_invalid);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_pressure();
      test_random();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- dbscan_point_clustering.f -----
rtl/dpc_pkg.sv
rtl/dpc_ram.sv
rtl/dpc_near.sv
rtl/dbscan_point_clustering.sv
tb/dbscan_point_clustering_tb.sv
